// File: hw/rtl/lwbc_pkg.sv
// Shared types and codes for the LRU write-back block cache.
`default_nettype none
package lwbc_pkg;
  localparam int BLOCK_NUMBER_BITS = 16;
  localparam int DATA_BITS = 64;
  localparam int NUM_BUFFERS_DEFAULT = 16;

  localparam logic [2:0] OP_READ       = 3'd0;
  localparam logic [2:0] OP_WRITE      = 3'd1;
  localparam logic [2:0] OP_SYNC_BLOCK = 3'd2;
  localparam logic [2:0] OP_SYNC_ALL   = 3'd3;
  localparam logic [2:0] OP_FILL       = 3'd4;

  localparam logic [2:0] K_DATA  = 3'd0;
  localparam logic [2:0] K_WB    = 3'd1;
  localparam logic [2:0] K_FETCH = 3'd2;
  localparam logic [2:0] K_DONE  = 3'd3;
  localparam logic [2:0] K_ERR   = 3'd4;

  typedef struct packed {
    logic [2:0]                   operation;
    logic [BLOCK_NUMBER_BITS-1:0] block_number;
    logic [DATA_BITS-1:0]         write_data;
  } cmd_t;

  typedef struct packed {
    logic [2:0]                   kind;
    logic [BLOCK_NUMBER_BITS-1:0] block_number_res;
    logic [DATA_BITS-1:0]         read_data;
    logic                         last;
  } res_t;
endpackage
`default_nettype wire

// File: hw/rtl/lru_writeback_block_cache_top.sv
// Top level of the fully associative LRU write-back block cache.
//
// Commands enter on cmd: a transfer happens at a clock edge with start high and
// busy low. Each result appears on result for one cycle with strobe high; the
// receiver cannot stall, so results are never held.
// A command is decoded in the cycle after its transfer; simple results
// (done, error, fill data, write hits) are registered at decode.
// A read hit or a sync_block write-back reads the data memory and shows it from S_MEMOUT.
// A miss allocates in S_ALLOC, after S_MEMOUT when a dirty victim is written back first.
// sync_all gives its write-backs in turn (memory read in S_SALL, then output in
// S_MEMOUT) after the decode, then clears the dirty order in S_SCLR.
// busy stays high until the last result of the command is registered; the
// next command may transfer in the cycle its final result is shown, or in the
// following cycle after sync_all while the dirty order is cleared.
// Tag match, free-slot search and LRU victim choice run in parallel over the
// tag and rank registers; block contents live in a one-port-read data memory.
// Reset clears valid, dirty, ranks and the pending-fill state at once; no
// clearing pass is needed.
`default_nettype none
module lru_writeback_block_cache_top #(
  parameter int NUM_BUFFERS = lwbc_pkg::NUM_BUFFERS_DEFAULT
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  output logic               busy,
  input  wire lwbc_pkg::cmd_t cmd,
  output logic               strobe,
  output lwbc_pkg::res_t     result
);
  localparam int IW = $clog2(NUM_BUFFERS);
  localparam int CW = $clog2(NUM_BUFFERS + 1);
  localparam int BN = lwbc_pkg::BLOCK_NUMBER_BITS;
  localparam int DB = lwbc_pkg::DATA_BITS;

  typedef enum logic [2:0] {S_IDLE, S_LOOK, S_MEMOUT, S_ALLOC, S_SALL, S_SCLR} state_t;

  state_t state, after;
  lwbc_pkg::cmd_t cmd_q;
  lwbc_pkg::res_t hold;

  logic [NUM_BUFFERS-1:0] valid, dirty;
  logic [BN-1:0] tag [NUM_BUFFERS];
  logic [IW-1:0] rrank [NUM_BUFFERS];
  logic [IW-1:0] drank [NUM_BUFFERS];
  logic [CW-1:0] dcount;
  logic          fill_pending;
  logic [IW-1:0] fill_slot, slot, k;

  logic [DB-1:0] mem [NUM_BUFFERS];
  logic [DB-1:0] mem_rdata;
  logic          mem_we;
  logic [IW-1:0] mem_waddr, mem_raddr;

  logic [NUM_BUFFERS-1:0] match_vec;
  logic          hit, has_free, found_sall;
  logic [IW-1:0] hit_idx, free_idx, victim_idx, sall_idx;
  logic          ok, is_rw;
  logic          touch_en, clean_en, mkdirty_en;
  logic [IW-1:0] touch_idx, clean_idx, mkdirty_idx;
  logic [CW-1:0] touch_r;

  assign busy = (state != S_IDLE);

  always_comb begin
    hit = 1'b0; hit_idx = '0; has_free = 1'b0; free_idx = '0;
    victim_idx = '0; found_sall = 1'b0; sall_idx = '0;
    for (int i = 0; i < NUM_BUFFERS; i++) begin
      match_vec[i] = valid[i] && (tag[i] == cmd_q.block_number);
      if (match_vec[i] && !hit) begin
        hit = 1'b1; hit_idx = IW'(i);
      end
      if (!valid[i] && !has_free) begin
        has_free = 1'b1; free_idx = IW'(i);
      end
      if (rrank[i] == IW'(NUM_BUFFERS - 1)) victim_idx = IW'(i);
      if (dirty[i] && drank[i] == k && !found_sall) begin
        found_sall = 1'b1; sall_idx = IW'(i);
      end
    end
  end

  always_comb begin
    ok = !fill_pending && (cmd_q.operation == lwbc_pkg::OP_READ ||
         cmd_q.operation == lwbc_pkg::OP_WRITE || cmd_q.operation == lwbc_pkg::OP_SYNC_BLOCK ||
         cmd_q.operation == lwbc_pkg::OP_SYNC_ALL);
    is_rw = (cmd_q.operation == lwbc_pkg::OP_READ) || (cmd_q.operation == lwbc_pkg::OP_WRITE);
    touch_en = ((state == S_LOOK) && ok && is_rw && hit) || (state == S_ALLOC);
    touch_idx = (state == S_ALLOC) ? slot : hit_idx;
    touch_r = valid[touch_idx] ? CW'(rrank[touch_idx]) : CW'(NUM_BUFFERS);
    clean_en = (state == S_LOOK) && ok &&
               ((is_rw && !hit && !has_free && dirty[victim_idx]) ||
                (cmd_q.operation == lwbc_pkg::OP_SYNC_BLOCK && hit && dirty[hit_idx]));
    clean_idx = (cmd_q.operation == lwbc_pkg::OP_SYNC_BLOCK) ? hit_idx : victim_idx;
    mkdirty_en = (cmd_q.operation == lwbc_pkg::OP_WRITE) &&
                 (((state == S_LOOK) && ok && hit) || (state == S_ALLOC));
    mkdirty_idx = (state == S_ALLOC) ? slot : hit_idx;
    mem_we = 1'b0; mem_waddr = hit_idx;
    mem_raddr = (state == S_SALL) ? sall_idx : (hit ? hit_idx : victim_idx);
    if (state == S_LOOK && cmd_q.operation == lwbc_pkg::OP_FILL && fill_pending) begin
      mem_we = 1'b1; mem_waddr = fill_slot;
    end else if (mkdirty_en) begin
      mem_we = 1'b1; mem_waddr = mkdirty_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= cmd_q.write_data;
    mem_rdata <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      after <= S_IDLE;
      valid <= '0;
      dirty <= '0;
      dcount <= '0;
      fill_pending <= 1'b0;
      fill_slot <= '0;
      slot <= '0;
      k <= '0;
      strobe <= 1'b0;
      for (int i = 0; i < NUM_BUFFERS; i++) begin
        rrank[i] <= '0;
        drank[i] <= '0;
      end
    end else begin
      strobe <= 1'b0;
      if (touch_en) begin
        for (int i = 0; i < NUM_BUFFERS; i++)
          if (IW'(i) != touch_idx && valid[i] && CW'(rrank[i]) < touch_r)
            rrank[i] <= rrank[i] + 1'b1;
        rrank[touch_idx] <= '0;
      end
      if (clean_en) begin
        for (int i = 0; i < NUM_BUFFERS; i++)
          if (IW'(i) != clean_idx && dirty[i] && drank[i] > drank[clean_idx])
            drank[i] <= drank[i] - 1'b1;
        dirty[clean_idx] <= 1'b0;
        drank[clean_idx] <= '0;
        dcount <= dcount - 1'b1;
      end
      unique case (state)
        S_IDLE: begin
          if (start) begin
            cmd_q <= cmd;
            state <= S_LOOK;
          end
        end
        S_LOOK: begin
          state <= S_IDLE;
          strobe <= 1'b1;
          result <= '{kind: lwbc_pkg::K_ERR, block_number_res: cmd_q.block_number,
                      read_data: '0, last: 1'b1};
          if (cmd_q.operation == lwbc_pkg::OP_FILL) begin
            if (fill_pending) begin
              fill_pending <= 1'b0;
              result <= '{kind: lwbc_pkg::K_DATA, block_number_res: tag[fill_slot],
                          read_data: cmd_q.write_data, last: 1'b1};
            end
          end else if (ok) begin
            hold <= '{kind: lwbc_pkg::K_WB, block_number_res: cmd_q.block_number,
                      read_data: '0, last: 1'b1};
            after <= S_IDLE;
            if (is_rw && !hit) begin
              strobe <= 1'b0;
              slot <= has_free ? free_idx : victim_idx;
              if (!has_free && dirty[victim_idx]) begin
                hold <= '{kind: lwbc_pkg::K_WB, block_number_res: tag[victim_idx],
                          read_data: '0, last: 1'b0};
                after <= S_ALLOC;
                state <= S_MEMOUT;
              end else begin
                state <= S_ALLOC;
              end
            end else begin
              case (cmd_q.operation)
                lwbc_pkg::OP_READ: begin
                  strobe <= 1'b0;
                  hold.kind <= lwbc_pkg::K_DATA;
                  state <= S_MEMOUT;
                end
                lwbc_pkg::OP_WRITE: begin
                  result.kind <= lwbc_pkg::K_DONE;
                  if (!dirty[hit_idx]) begin
                    dirty[hit_idx] <= 1'b1;
                    drank[hit_idx] <= IW'(dcount);
                    dcount <= dcount + 1'b1;
                  end
                end
                lwbc_pkg::OP_SYNC_BLOCK: begin
                  if (hit && dirty[hit_idx]) begin
                    strobe <= 1'b0;
                    state <= S_MEMOUT;
                  end else begin
                    result.kind <= lwbc_pkg::K_DONE;
                  end
                end
                default: begin
                  if (dcount == '0) begin
                    result.kind <= lwbc_pkg::K_DONE;
                  end else begin
                    strobe <= 1'b0;
                    k <= '0;
                    state <= S_SALL;
                  end
                end
              endcase
            end
          end
        end
        S_MEMOUT: begin
          strobe <= 1'b1;
          result <= '{kind: hold.kind, block_number_res: hold.block_number_res,
                      read_data: mem_rdata, last: hold.last};
          state <= after;
        end
        S_ALLOC: begin
          valid[slot] <= 1'b1;
          dirty[slot] <= 1'b0;
          drank[slot] <= '0;
          tag[slot] <= cmd_q.block_number;
          strobe <= 1'b1;
          state <= S_IDLE;
          if (cmd_q.operation == lwbc_pkg::OP_READ) begin
            fill_pending <= 1'b1;
            fill_slot <= slot;
            result <= '{kind: lwbc_pkg::K_FETCH, block_number_res: cmd_q.block_number,
                        read_data: '0, last: 1'b1};
          end else begin
            dirty[slot] <= 1'b1;
            drank[slot] <= IW'(dcount);
            dcount <= dcount + 1'b1;
            result <= '{kind: lwbc_pkg::K_DONE, block_number_res: cmd_q.block_number,
                        read_data: '0, last: 1'b1};
          end
        end
        S_SALL: begin
          hold <= '{kind: lwbc_pkg::K_WB, block_number_res: tag[sall_idx],
                    read_data: '0, last: (CW'(k) + 1'b1 == dcount)};
          after <= (CW'(k) + 1'b1 == dcount) ? S_SCLR : S_SALL;
          k <= k + 1'b1;
          state <= S_MEMOUT;
        end
        S_SCLR: begin
          dirty <= '0;
          dcount <= '0;
          for (int i = 0; i < NUM_BUFFERS; i++) drank[i] <= '0;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_busy_after_transfer: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("busy not raised after transfer");
  a_fetch_sets_pending: assert property (@(posedge clk) disable iff (rst)
    strobe && result.kind == lwbc_pkg::K_FETCH |-> fill_pending)
    else $error("fetch without pending fill");
  a_unique_tags: assert property (@(posedge clk) disable iff (rst)
    state == S_LOOK |-> $onehot0(match_vec)) else $error("duplicate cached block");
  a_dirty_count: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> dcount == CW'($countones(dirty))) else $error("dirty count off");
`endif
endmodule
`default_nettype wire

// File: tb/sv/testbench.sv
// Self-checking testbench for the LRU write-back block cache: directed and random commands.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NBUF = 16;
  localparam int STALL_LIMIT = 2000;

  // Predicts the cache's results and holds them until they arrive.
  class cache_scoreboard;
    bit                    valid [NBUF];
    bit                    dirty [NBUF];
    logic [15:0]           tag [NBUF];
    logic [63:0]           contents [NBUF];
    int unsigned           age [NBUF];
    int unsigned           dirty_pos [NBUF];
    bit                    fill_wait;
    int                    fill_idx;
    lwbc_pkg::res_t        pending_results [$];
    int                    errors;

    function void clear();
      for (int i = 0; i < NBUF; i++) begin
        valid[i] = 1'b0; dirty[i] = 1'b0; tag[i] = '0; contents[i] = '0;
        age[i] = 0; dirty_pos[i] = 0;
      end
      fill_wait = 1'b0; fill_idx = 0; errors = 0;
      pending_results.delete();
    endfunction

    function void push(logic [2:0] k, logic [15:0] b, logic [63:0] d, bit l);
      lwbc_pkg::res_t r;
      r.kind = k; r.block_number_res = b; r.read_data = d; r.last = l;
      pending_results.push_back(r);
    endfunction

    function int find_slot(logic [15:0] b);
      for (int i = 0; i < NBUF; i++)
        if (valid[i] && tag[i] == b) return i;
      return -1;
    endfunction

    function void refresh(int s);
      int unsigned r;
      r = valid[s] ? age[s] : NBUF;
      for (int i = 0; i < NBUF; i++)
        if (i != s && valid[i] && age[i] < r) age[i]++;
      age[s] = 0;
    endfunction

    function int unsigned dirty_count();
      int unsigned c;
      c = 0;
      for (int i = 0; i < NBUF; i++) if (valid[i] && dirty[i]) c++;
      return c;
    endfunction

    function void set_dirty(int s);
      if (dirty[s]) return;
      dirty_pos[s] = dirty_count();
      dirty[s] = 1'b1;
    endfunction

    function void set_clean(int s);
      if (!dirty[s]) return;
      for (int i = 0; i < NBUF; i++)
        if (i != s && valid[i] && dirty[i] && dirty_pos[i] > dirty_pos[s]) dirty_pos[i]--;
      dirty[s] = 1'b0;
      dirty_pos[s] = 0;
    endfunction

    function int claim_slot(logic [15:0] b);
      int s;
      int unsigned best;
      s = -1;
      for (int i = 0; i < NBUF; i++)
        if (!valid[i]) begin s = i; break; end
      if (s < 0) begin
        best = 0; s = 0;
        for (int i = 0; i < NBUF; i++)
          if (age[i] >= best) begin best = age[i]; s = i; end
        if (dirty[s]) begin
          push(lwbc_pkg::K_WB, tag[s], contents[s], 1'b0);
          set_clean(s);
        end
      end
      refresh(s);
      valid[s] = 1'b1; dirty[s] = 1'b0; dirty_pos[s] = 0; tag[s] = b;
      return s;
    endfunction

    function void note_command(lwbc_pkg::cmd_t c);
      int s;
      int unsigned total;
      if (c.operation == lwbc_pkg::OP_FILL) begin
        if (!fill_wait) begin
          push(lwbc_pkg::K_ERR, c.block_number, '0, 1'b1);
          return;
        end
        contents[fill_idx] = c.write_data;
        fill_wait = 1'b0;
        push(lwbc_pkg::K_DATA, tag[fill_idx], c.write_data, 1'b1);
        return;
      end
      if (fill_wait || c.operation > lwbc_pkg::OP_FILL) begin
        push(lwbc_pkg::K_ERR, c.block_number, '0, 1'b1);
        return;
      end
      case (c.operation)
        lwbc_pkg::OP_READ: begin
          s = find_slot(c.block_number);
          if (s >= 0) begin
            refresh(s);
            push(lwbc_pkg::K_DATA, c.block_number, contents[s], 1'b1);
          end else begin
            s = claim_slot(c.block_number);
            fill_wait = 1'b1; fill_idx = s;
            push(lwbc_pkg::K_FETCH, c.block_number, '0, 1'b1);
          end
        end
        lwbc_pkg::OP_WRITE: begin
          s = find_slot(c.block_number);
          if (s >= 0) refresh(s);
          else s = claim_slot(c.block_number);
          set_dirty(s);
          contents[s] = c.write_data;
          push(lwbc_pkg::K_DONE, c.block_number, '0, 1'b1);
        end
        lwbc_pkg::OP_SYNC_BLOCK: begin
          s = find_slot(c.block_number);
          if (s >= 0 && dirty[s]) begin
            push(lwbc_pkg::K_WB, c.block_number, contents[s], 1'b1);
            set_clean(s);
          end else push(lwbc_pkg::K_DONE, c.block_number, '0, 1'b1);
        end
        default: begin
          total = dirty_count();
          if (total == 0) push(lwbc_pkg::K_DONE, c.block_number, '0, 1'b1);
          else begin
            for (int unsigned k = 0; k < total; k++)
              for (int i = 0; i < NBUF; i++)
                if (valid[i] && dirty[i] && dirty_pos[i] == k) begin
                  push(lwbc_pkg::K_WB, tag[i], contents[i], k + 1 == total);
                  break;
                end
            for (int i = 0; i < NBUF; i++) begin dirty[i] = 1'b0; dirty_pos[i] = 0; end
          end
        end
      endcase
    endfunction

    task report_mismatch(string msg);
      errors++;
      $display("mismatch at %0t: %s", $time, msg);
    endtask

    task check_result(lwbc_pkg::res_t got);
      lwbc_pkg::res_t want;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result kind=%0d blk=%h", got.kind,
                                  got.block_number_res));
        return;
      end
      want = pending_results.pop_front();
      if (got.kind !== want.kind)
        report_mismatch($sformatf("kind %0d, want %0d", got.kind, want.kind));
      if (got.block_number_res !== want.block_number_res)
        report_mismatch($sformatf("block %h, want %h", got.block_number_res,
                                  want.block_number_res));
      if (got.read_data !== want.read_data)
        report_mismatch($sformatf("data %h, want %h", got.read_data, want.read_data));
      if (got.last !== want.last)
        report_mismatch($sformatf("last %b, want %b", got.last, want.last));
    endtask
  endclass

  logic clk = 0;
  logic rst = 1;
  logic start = 0;
  logic busy;
  lwbc_pkg::cmd_t cmd = '0;
  logic strobe;
  lwbc_pkg::res_t result;
  cache_scoreboard sb = new();
  int idle_cycles = 0;
  logic [15:0] hot_blocks [6];

  lru_writeback_block_cache_top u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .cmd(cmd), .strobe(strobe), .result(result)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (strobe) sb.check_result(result);
      if ((start && !busy) || strobe) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // One transfer; start drops at the accepting edge and may rise again after the following edge.
  task automatic send(logic [2:0] op, logic [15:0] b, logic [63:0] d, bit gaps);
    lwbc_pkg::cmd_t c;
    int gap;
    c.operation = op; c.block_number = b; c.write_data = d;
    gap = gaps ? int'($urandom_range(0, 3)) : 0;
    repeat (gap) @(posedge clk);
    start <= 1'b1;
    cmd <= c;
    do @(posedge clk); while (busy);
    sb.note_command(c);
    start <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  initial begin
    logic [2:0] op;
    logic [15:0] b;
    sb.clear();
    for (int i = 0; i < 6; i++) hot_blocks[i] = 16'($urandom);
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed
    send(lwbc_pkg::OP_SYNC_ALL, 16'h0000, '0, 1'b0);
    send(lwbc_pkg::OP_FILL, 16'hffff, '1, 1'b0);
    send(lwbc_pkg::OP_WRITE, 16'hffff, '1, 1'b0);
    send(lwbc_pkg::OP_WRITE, 16'h0000, 64'h0, 1'b0);
    send(lwbc_pkg::OP_READ, 16'hffff, '0, 1'b0);
    send(lwbc_pkg::OP_SYNC_BLOCK, 16'hffff, '0, 1'b0);
    send(lwbc_pkg::OP_SYNC_BLOCK, 16'hffff, '0, 1'b0);
    send(lwbc_pkg::OP_SYNC_BLOCK, 16'h1234, '0, 1'b0);
    send(lwbc_pkg::OP_READ, 16'h5555, '0, 1'b0);
    send(lwbc_pkg::OP_WRITE, 16'h5555, '0, 1'b0);
    send(lwbc_pkg::OP_FILL, 16'h0000, 64'haaaa_aaaa_5555_5555, 1'b0);
    send(3'd5, 16'haaaa, '0, 1'b0);
    send(3'd6, 16'h0001, '0, 1'b0);
    send(3'd7, 16'h8000, '1, 1'b0);
    for (int i = 0; i < 17; i++)
      send(lwbc_pkg::OP_WRITE, 16'h0100 + 16'(i), rand64(), 1'b0);
    send(lwbc_pkg::OP_SYNC_ALL, 16'h0000, '0, 1'b0);
    send(lwbc_pkg::OP_SYNC_ALL, 16'h0000, '0, 1'b0);

    // random: mostly a small working set so hits, evictions and fills recur
    for (int n = 0; n < 150; n++) begin
      if (sb.fill_wait && $urandom_range(0, 9) != 0) begin
        send(lwbc_pkg::OP_FILL, 16'($urandom), rand64(), 1'b1);
        continue;
      end
      case ($urandom_range(0, 19))
        0,1,2,3,4,5: op = lwbc_pkg::OP_READ;
        6,7,8,9,10,11: op = lwbc_pkg::OP_WRITE;
        12,13,14: op = lwbc_pkg::OP_SYNC_BLOCK;
        15,16: op = lwbc_pkg::OP_SYNC_ALL;
        17: op = lwbc_pkg::OP_FILL;
        default: op = 3'($urandom_range(5, 7));
      endcase
      if ($urandom_range(0, 3) == 0) b = 16'($urandom);
      else if ($urandom_range(0, 1) == 0) b = hot_blocks[$urandom_range(0, 5)];
      else b = 16'h0200 + 16'($urandom_range(0, 19));
      send(op, b, rand64(), $urandom_range(0, 3) != 0);
    end
    if (sb.fill_wait) send(lwbc_pkg::OP_FILL, 16'h0, rand64(), 1'b0);

    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

// File: sim.f
hw/rtl/lwbc_pkg.sv
hw/rtl/lru_writeback_block_cache_top.sv
tb/sv/testbench.sv
